// File: rtl/ccf_pkg.sv
package ccf_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_FREQ_TOL   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BEAM_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TIME_TOL   = 2'd2;

	localparam logic [31:0] FREQ_TOL_RESET   = 32'd65536;
	localparam logic [31:0] BEAM_LIMIT_RESET = 32'd65536;
	localparam logic [31:0] TIME_TOL_RESET   = 32'd32768;

	localparam logic [1:0] OP_STORE = 2'd0;
	localparam logic [1:0] OP_TEST  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam int MATCH_W  = 11;
	localparam int POINTS_W = 12;
	localparam logic [31:0] MATCH_MAX  = 32'd2047;
	localparam logic [31:0] POINTS_MAX = 32'd4095;

	localparam int ENTRY_W = 96;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        frequency;
		logic [31:0]        start_beam;
		logic signed [31:0] start_time;
		logic [31:0]        dispersion;
	} ccf_in_t;

	typedef struct packed {
		logic                keep;
		logic [MATCH_W-1:0]  match_count;
		logic [POINTS_W-1:0] interference_points;
	} ccf_out_t;

endpackage

// File: rtl/candidate_coincidence_filter_top.sv
// Candidate coincidence filter.
// Input channel (in_valid, in_stall, in_data) carries store, test and clear
// items; output channel (out_valid, out_stall, out_data) carries one result
// per test item. Store and clear items give no result.
// A test item walks the stored table one entry per cycle through the read
// port of the table memory; the result then sits in the output register.
// Input is stalled while a test walk runs. A new item is taken while a
// result still waits; a finished walk holds until the output register is
// free, so a stalled receiver eventually stalls the input. Registers are
// written through cfg_wr_en, cfg_index and cfg_data while the block is
// idle, a duty of the user that the block does not enforce; writes to an
// unused index are ignored. After reset the table is empty, the registers
// hold their defaults and no result is pending. The table memory needs no
// clearing pass since only entries below the stored count are ever read.
module candidate_coincidence_filter_top #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [ccf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ccf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  ccf_pkg::ccf_in_t                   in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output ccf_pkg::ccf_out_t                  out_data
);

	import ccf_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = $clog2(3 * TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_WALK   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]         state_q;
	logic [31:0]        freq_tol_q, beam_limit_q, time_tol_q;
	logic [CW-1:0]      count_q, rd_q;
	logic [31:0]        freq_q, beam_q, time_q;
	logic               dm_zero_q;
	logic               vld_s1, vld_s2;
	logic [31:0]        fd_s2, bd_s2;
	logic [32:0]        td_s2;
	logic [CW-1:0]      match_q;
	logic [PW-1:0]      points_q;
	logic               out_valid_q;
	ccf_out_t           out_q;

	logic               in_fire, rd_en, wr_en, full;
	logic [ENTRY_W-1:0] wr_data, rd_data;
	logic [31:0]        ent_freq, ent_beam, ent_time;
	logic [32:0]        f_ab, f_ba, b_ab, b_ba;
	logic [32:0]        t_a, t_b, t_ab, t_ba;
	logic               hit;
	logic [1:0]         inc;
	logic [31:0]        match_ext, points_ext;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign wr_en    = in_fire && (in_data.opcode == OP_STORE) && !full;
	assign wr_data  = {in_data.frequency, in_data.start_beam, in_data.start_time};
	assign rd_en    = (state_q == ST_WALK) && (rd_q != count_q);

	ccf_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_q[AW-1:0]),
		.rd_data(rd_data)
	);

	assign ent_freq = rd_data[95:64];
	assign ent_beam = rd_data[63:32];
	assign ent_time = rd_data[31:0];

	always_comb begin
		f_ab = {1'b0, freq_q} - {1'b0, ent_freq};
		f_ba = {1'b0, ent_freq} - {1'b0, freq_q};
		b_ab = {1'b0, beam_q} - {1'b0, ent_beam};
		b_ba = {1'b0, ent_beam} - {1'b0, beam_q};
		t_a  = {time_q[31], time_q};
		t_b  = {ent_time[31], ent_time};
		t_ab = t_a - t_b;
		t_ba = t_b - t_a;
	end

	always_comb begin
		hit = (fd_s2 < freq_tol_q);
		inc = 2'(bd_s2 > beam_limit_q) + 2'(td_s2 > {1'b0, time_tol_q}) + 2'(dm_zero_q);
		match_ext  = 32'(match_q);
		points_ext = 32'(points_q);
	end

	always_ff @(posedge clk) begin
		if (in_fire && (in_data.opcode == OP_TEST)) begin
			freq_q    <= in_data.frequency;
			beam_q    <= in_data.start_beam;
			time_q    <= in_data.start_time;
			dm_zero_q <= (in_data.dispersion == 32'd0);
		end
		if (vld_s1) begin
			fd_s2 <= f_ab[32] ? f_ba[31:0] : f_ab[31:0];
			bd_s2 <= b_ab[32] ? b_ba[31:0] : b_ab[31:0];
			td_s2 <= t_ab[32] ? t_ba : t_ab;
		end
		if (state_q == ST_FINISH && (!out_valid_q || !out_stall)) begin
			out_q.keep                <= (points_ext <= match_ext);
			out_q.match_count         <= (match_ext > MATCH_MAX) ?
				MATCH_MAX[MATCH_W-1:0] : match_ext[MATCH_W-1:0];
			out_q.interference_points <= (points_ext > POINTS_MAX) ?
				POINTS_MAX[POINTS_W-1:0] : points_ext[POINTS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_tol_q   <= FREQ_TOL_RESET;
			beam_limit_q <= BEAM_LIMIT_RESET;
			time_tol_q   <= TIME_TOL_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FREQ_TOL:   freq_tol_q   <= cfg_data;
				REG_BEAM_LIMIT: beam_limit_q <= cfg_data;
				REG_TIME_TOL:   time_tol_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			match_q     <= '0;
			points_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (vld_s2 && hit) begin
				match_q  <= match_q + CW'(1);
				points_q <= points_q + PW'(inc);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_data.opcode)
							OP_STORE: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_TEST: begin
								rd_q     <= '0;
								match_q  <= '0;
								points_q <= '0;
								state_q  <= ST_WALK;
							end
							OP_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (rd_en) begin
						rd_q <= rd_q + CW'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("stored count beyond table depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_q < count_q))
		else $error("table read beyond stored count");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result appeared without a finished walk");

	a_pipe_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (state_q == ST_WALK || state_q == ST_DRAIN))
		else $error("compare stage active outside a walk");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (!vld_s1 && !vld_s2))
		else $error("result taken before the pipeline drained");
`endif

endmodule

// File: rtl/ccf_ram.sv
module ccf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
